FILE: hdl/dfr_pkg.sv
// dfr_pkg: shared constants, types and helper functions for the framed packet deframer
// used by the top level, dfr_scan and dfr_queue; depends on nothing

package dfr_pkg;

   localparam int WINDOW_DEPTH = 32;
   localparam int WIN_AW       = $clog2(WINDOW_DEPTH);
   localparam int FILL_W       = $clog2(WINDOW_DEPTH + 1);
   localparam int TOT_W        = 9;

   localparam int DATA_W = 8;
   localparam int LEN_W  = 5;
   localparam int KIND_W = 3;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   localparam int CSR_IW = 2;
   localparam logic [CSR_IW-1:0] CSR_HEADER_FIRST  = CSR_IW'(0);
   localparam logic [CSR_IW-1:0] CSR_HEADER_SECOND = CSR_IW'(1);

   localparam logic [DATA_W-1:0] HEADER_FIRST_RESET  = 8'hAA;
   localparam logic [DATA_W-1:0] HEADER_SECOND_RESET = 8'h55;

   localparam logic [DATA_W-1:0] CMD_ACCEL     = 8'h10;
   localparam logic [DATA_W-1:0] CMD_WAYPOINTS = 8'h30;
   localparam logic [DATA_W-1:0] CMD_START     = 8'h31;
   localparam logic [DATA_W-1:0] CMD_STOP      = 8'h32;

   localparam logic [DATA_W-1:0] LEN_ACCEL     = 8'd8;
   localparam logic [DATA_W-1:0] LEN_WAYPOINTS = 8'd24;
   localparam logic [DATA_W-1:0] LEN_NONE      = 8'd0;

   localparam logic [KIND_W-1:0] KIND_UNKNOWN   = 3'd0;
   localparam logic [KIND_W-1:0] KIND_ACCEL     = 3'd1;
   localparam logic [KIND_W-1:0] KIND_WAYPOINTS = 3'd2;
   localparam logic [KIND_W-1:0] KIND_START     = 3'd3;
   localparam logic [KIND_W-1:0] KIND_STOP      = 3'd4;

   // framing overhead: two sync bytes, command, length, checksum
   localparam int FRAME_OVERHEAD = 5;
   localparam int MIN_SCAN_FILL  = 4;
   localparam int PAYLOAD_OFFSET = 4;

   typedef struct packed {
      logic [DATA_W-1:0] first;
      logic [DATA_W-1:0] second;
   } hdr_type;

   typedef struct packed {
      logic [DATA_W-1:0] frame_command;
      logic [LEN_W-1:0]  frame_length;
      logic [KIND_W-1:0] frame_kind;
      logic              has_payload;
      logic [LEN_W-1:0]  byte_index;
      logic [DATA_W-1:0] payload_byte;
      logic              last_of_frame;
   } rsp_type;

   // circular window address: base plus step, step at most the window depth
   function automatic logic [WIN_AW-1:0] wrap_add(input logic [WIN_AW-1:0] base,
                                                  input logic [FILL_W-1:0] step);
      logic [FILL_W:0] sum;
      sum = (FILL_W + 1)'(base) + (FILL_W + 1)'(step);
      if (sum >= (FILL_W + 1)'(WINDOW_DEPTH)) begin
         sum = sum - (FILL_W + 1)'(WINDOW_DEPTH);
      end
      return sum[WIN_AW-1:0];
   endfunction

   function automatic logic [KIND_W-1:0] kind_of(input logic [DATA_W-1:0] cmd,
                                                 input logic [DATA_W-1:0] len);
      logic [KIND_W-1:0] kind;
      kind = KIND_UNKNOWN;
      if (cmd == CMD_ACCEL && len == LEN_ACCEL) begin
         kind = KIND_ACCEL;
      end else if (cmd == CMD_WAYPOINTS && len == LEN_WAYPOINTS) begin
         kind = KIND_WAYPOINTS;
      end else if (cmd == CMD_START && len == LEN_NONE) begin
         kind = KIND_START;
      end else if (cmd == CMD_STOP && len == LEN_NONE) begin
         kind = KIND_STOP;
      end
      return kind;
   endfunction

endpackage

FILE: hdl/xor_framed_packet_deframer.sv
// xor_framed_packet_deframer: top level; sync byte registers, frame scanner and result queue
// depends on dfr_pkg, dfr_scan, dfr_queue (and dfr_ram through dfr_scan)
//
//   channel   ports                       handshake
//   req_      req_data_byte               push / full
//   rsp_      rsp_frame_* and friends     empty / pop
//   csr_      csr_index, csr_data         csr_valid / csr_ready (always ready)
//
// one byte is taken at a time; full stays high while the window is rescanned
// per byte: the rescan ends when fewer than 4 bytes are held or a frame is still incomplete;
// each sync miss, oversize length or checksum miss drops one byte from the window; a good
// frame yields one result per payload byte, or one marker if zero-length, and is dropped;
// the rescan is longest when every offset of a full window looks like a frame
// the scanner waits while the 4 entry result queue is full; reset empties window and queue

module xor_framed_packet_deframer (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_push,
   output logic                        req_full,
   input  logic [dfr_pkg::DATA_W-1:0]  req_data_byte,
   output logic                        rsp_empty,
   input  logic                        rsp_pop,
   output logic [dfr_pkg::DATA_W-1:0]  rsp_frame_command,
   output logic [dfr_pkg::LEN_W-1:0]   rsp_frame_length,
   output logic [dfr_pkg::KIND_W-1:0]  rsp_frame_kind,
   output logic                        rsp_has_payload,
   output logic [dfr_pkg::LEN_W-1:0]   rsp_byte_index,
   output logic [dfr_pkg::DATA_W-1:0]  rsp_payload_byte,
   output logic                        rsp_last_of_frame,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [dfr_pkg::CSR_IW-1:0]  csr_index,
   input  logic [dfr_pkg::DATA_W-1:0]  csr_data
);

   dfr_pkg::hdr_type  hdr_ff, hdr_in;
   dfr_pkg::rsp_type  scan_rsp;
   dfr_pkg::rsp_type  head_rsp;
   logic              scan_busy;
   logic              scan_push;
   logic              queue_full;

   assign csr_ready = 1'b1;
   assign req_full  = scan_busy;

   always_comb begin
      hdr_in = hdr_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            dfr_pkg::CSR_HEADER_FIRST:  hdr_in.first  = csr_data;
            dfr_pkg::CSR_HEADER_SECOND: hdr_in.second = csr_data;
            default: begin
               hdr_in = hdr_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_ff.first  <= dfr_pkg::HEADER_FIRST_RESET;
         hdr_ff.second <= dfr_pkg::HEADER_SECOND_RESET;
      end else begin
         hdr_ff <= hdr_in;
      end
   end

   dfr_scan u_scan (
      .clock     (clock),
      .reset     (reset),
      .hdr       (hdr_ff),
      .byte_push (req_push),
      .byte_data (req_data_byte),
      .busy      (scan_busy),
      .rsp_push  (scan_push),
      .rsp_data  (scan_rsp),
      .rsp_full  (queue_full)
   );

   dfr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (scan_push),
      .push_data (scan_rsp),
      .full      (queue_full),
      .pop       (rsp_pop),
      .empty     (rsp_empty),
      .head_data (head_rsp)
   );

   assign rsp_frame_command = head_rsp.frame_command;
   assign rsp_frame_length  = head_rsp.frame_length;
   assign rsp_frame_kind    = head_rsp.frame_kind;
   assign rsp_has_payload   = head_rsp.has_payload;
   assign rsp_byte_index    = head_rsp.byte_index;
   assign rsp_payload_byte  = head_rsp.payload_byte;
   assign rsp_last_of_frame = head_rsp.last_of_frame;

endmodule

FILE: hdl/dfr_ram.sv
// dfr_ram: generic single write port, single read port ram with registered read data
// no dependencies

module dfr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

FILE: hdl/dfr_queue.sv
// dfr_queue: short result queue between the frame scanner and the result port
// depends on dfr_pkg

module dfr_queue (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  dfr_pkg::rsp_type push_data,
   output logic            full,
   input  logic            pop,
   output logic            empty,
   output dfr_pkg::rsp_type head_data
);

   dfr_pkg::rsp_type                    slot_ff [dfr_pkg::QUEUE_DEPTH];
   logic [dfr_pkg::QUEUE_AW-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [dfr_pkg::QUEUE_AW-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [dfr_pkg::QUEUE_CW-1:0]        count_ff, count_in;
   logic                                do_push, do_pop;

   assign full      = (count_ff == dfr_pkg::QUEUE_CW'(dfr_pkg::QUEUE_DEPTH));
   assign empty     = (count_ff == '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;
   assign head_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == dfr_pkg::QUEUE_AW'(dfr_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == dfr_pkg::QUEUE_AW'(dfr_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: hdl/dfr_scan.sv
// dfr_scan: byte window and frame scanner; appends bytes, hunts for sync, checks
// length and checksum, and pushes payload or marker results; depends on dfr_pkg and dfr_ram

module dfr_scan (
   input  logic                        clock,
   input  logic                        reset,
   input  dfr_pkg::hdr_type            hdr,
   input  logic                        byte_push,
   input  logic [dfr_pkg::DATA_W-1:0]  byte_data,
   output logic                        busy,
   output logic                        rsp_push,
   output dfr_pkg::rsp_type            rsp_data,
   input  logic                        rsp_full
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_CHECK,
      S_H0,
      S_H1,
      S_CMD,
      S_LEN,
      S_SUM,
      S_MARK,
      S_EMIT
   } state_type;

   state_type                          state_ff, state_in;
   logic [dfr_pkg::WIN_AW-1:0]         head_ff, head_in;
   logic [dfr_pkg::FILL_W-1:0]         fill_ff, fill_in;
   logic [dfr_pkg::DATA_W-1:0]         cmd_ff, cmd_in;
   logic [dfr_pkg::DATA_W-1:0]         len_ff, len_in;
   logic [dfr_pkg::DATA_W-1:0]         sum_ff, sum_in;
   logic [dfr_pkg::WIN_AW-1:0]         idx_ff, idx_in;

   logic                               wr_en;
   logic [dfr_pkg::WIN_AW-1:0]         wr_addr;
   logic [dfr_pkg::WIN_AW-1:0]         rd_off;
   logic [dfr_pkg::WIN_AW-1:0]         rd_addr;
   logic [dfr_pkg::DATA_W-1:0]         rd_data;
   logic [dfr_pkg::TOT_W-1:0]          len_total;
   logic [dfr_pkg::FILL_W-1:0]         frame_total;
   logic [dfr_pkg::KIND_W-1:0]         kind;
   logic                               idx_at_len;
   logic                               idx_last;

   assign busy        = (state_ff != S_IDLE);
   assign wr_addr     = dfr_pkg::wrap_add(head_ff, fill_ff);
   assign rd_addr     = dfr_pkg::wrap_add(head_ff, dfr_pkg::FILL_W'(rd_off));
   assign len_total   = dfr_pkg::TOT_W'(rd_data) + dfr_pkg::TOT_W'(dfr_pkg::FRAME_OVERHEAD);
   assign frame_total = dfr_pkg::FILL_W'(len_ff) + dfr_pkg::FILL_W'(dfr_pkg::FRAME_OVERHEAD);
   assign kind        = dfr_pkg::kind_of(cmd_ff, len_ff);
   assign idx_at_len  = (dfr_pkg::DATA_W'(idx_ff) == len_ff);
   assign idx_last    = (dfr_pkg::DATA_W'(idx_ff) + 1'b1 == len_ff);

   dfr_ram #(
      .WIDTH (dfr_pkg::DATA_W),
      .DEPTH (dfr_pkg::WINDOW_DEPTH)
   ) u_window (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (byte_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in = state_ff;
      head_in  = head_ff;
      fill_in  = fill_ff;
      cmd_in   = cmd_ff;
      len_in   = len_ff;
      sum_in   = sum_ff;
      idx_in   = idx_ff;
      wr_en    = 1'b0;
      rd_off   = '0;
      rsp_push = 1'b0;
      rsp_data = '0;

      case (state_ff)
         S_IDLE: begin
            if (byte_push) begin
               wr_en    = 1'b1;
               state_in = S_CHECK;
               if (fill_ff == dfr_pkg::FILL_W'(dfr_pkg::WINDOW_DEPTH)) begin
                  head_in = dfr_pkg::wrap_add(head_ff, dfr_pkg::FILL_W'(1));
               end else begin
                  fill_in = fill_ff + 1'b1;
               end
            end
         end
         S_CHECK: begin
            rd_off = '0;
            if (fill_ff < dfr_pkg::FILL_W'(dfr_pkg::MIN_SCAN_FILL)) begin
               state_in = S_IDLE;
            end else begin
               state_in = S_H0;
            end
         end
         S_H0: begin
            rd_off = dfr_pkg::WIN_AW'(1);
            if (rd_data != hdr.first) begin
               head_in  = dfr_pkg::wrap_add(head_ff, dfr_pkg::FILL_W'(1));
               fill_in  = fill_ff - 1'b1;
               state_in = S_CHECK;
            end else begin
               state_in = S_H1;
            end
         end
         S_H1: begin
            rd_off = dfr_pkg::WIN_AW'(2);
            if (rd_data != hdr.second) begin
               head_in  = dfr_pkg::wrap_add(head_ff, dfr_pkg::FILL_W'(1));
               fill_in  = fill_ff - 1'b1;
               state_in = S_CHECK;
            end else begin
               state_in = S_CMD;
            end
         end
         S_CMD: begin
            rd_off   = dfr_pkg::WIN_AW'(3);
            cmd_in   = rd_data;
            state_in = S_LEN;
         end
         S_LEN: begin
            rd_off = dfr_pkg::WIN_AW'(dfr_pkg::PAYLOAD_OFFSET);
            len_in = rd_data;
            sum_in = cmd_ff ^ rd_data;
            idx_in = '0;
            if (len_total > dfr_pkg::TOT_W'(dfr_pkg::WINDOW_DEPTH)) begin
               head_in  = dfr_pkg::wrap_add(head_ff, dfr_pkg::FILL_W'(1));
               fill_in  = fill_ff - 1'b1;
               state_in = S_CHECK;
            end else if (dfr_pkg::TOT_W'(fill_ff) < len_total) begin
               state_in = S_IDLE;
            end else begin
               state_in = S_SUM;
            end
         end
         S_SUM: begin
            if (idx_at_len) begin
               // rd_data holds the trailing checksum byte
               if (rd_data != sum_ff) begin
                  head_in  = dfr_pkg::wrap_add(head_ff, dfr_pkg::FILL_W'(1));
                  fill_in  = fill_ff - 1'b1;
                  state_in = S_CHECK;
               end else if (len_ff == dfr_pkg::LEN_NONE) begin
                  state_in = S_MARK;
               end else begin
                  rd_off   = dfr_pkg::WIN_AW'(dfr_pkg::PAYLOAD_OFFSET);
                  idx_in   = '0;
                  state_in = S_EMIT;
               end
            end else begin
               sum_in = sum_ff ^ rd_data;
               idx_in = idx_ff + 1'b1;
               rd_off = idx_ff + dfr_pkg::WIN_AW'(dfr_pkg::PAYLOAD_OFFSET + 1);
            end
         end
         S_MARK: begin
            if (!rsp_full) begin
               rsp_push               = 1'b1;
               rsp_data.frame_command = cmd_ff;
               rsp_data.frame_kind    = kind;
               rsp_data.last_of_frame = 1'b1;
               head_in  = dfr_pkg::wrap_add(head_ff, frame_total);
               fill_in  = fill_ff - frame_total;
               state_in = S_CHECK;
            end
         end
         S_EMIT: begin
            rd_off = idx_ff + dfr_pkg::WIN_AW'(dfr_pkg::PAYLOAD_OFFSET);
            if (!rsp_full) begin
               rsp_push               = 1'b1;
               rsp_data.frame_command = cmd_ff;
               rsp_data.frame_length  = len_ff[dfr_pkg::LEN_W-1:0];
               rsp_data.frame_kind    = kind;
               rsp_data.has_payload   = 1'b1;
               rsp_data.byte_index    = dfr_pkg::LEN_W'(idx_ff);
               rsp_data.payload_byte  = rd_data;
               rsp_data.last_of_frame = idx_last;
               if (idx_last) begin
                  head_in  = dfr_pkg::wrap_add(head_ff, frame_total);
                  fill_in  = fill_ff - frame_total;
                  state_in = S_CHECK;
               end else begin
                  idx_in = idx_ff + 1'b1;
                  rd_off = idx_ff + dfr_pkg::WIN_AW'(dfr_pkg::PAYLOAD_OFFSET + 1);
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         head_ff  <= '0;
         fill_ff  <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         fill_ff  <= fill_in;
      end
      cmd_ff <= cmd_in;
      len_ff <= len_in;
      sum_ff <= sum_in;
      idx_ff <= idx_in;
   end

endmodule
